>>> design/block_range_sum_table_defines.svh
// assertion macros shared by the range sum table
`ifndef BLOCK_RANGE_SUM_TABLE_DEFINES_SVH
`define BLOCK_RANGE_SUM_TABLE_DEFINES_SVH

// checked outside reset
`define BRST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BRST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/brst_pkg.sv
package brst_pkg;

  localparam int ELEMENTS_DEF  = 256;
  localparam int BLOCK_LEN_DEF = 16;

  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int SUM_W = 40;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_DONE
  } state_t;

  function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

>>> design/block_range_sum_table.sv
// write item: old element and block sum read in the accept cycle, write-back the next;
//   next item taken once the write-back is done
// query item: one memory read per cycle, up to (BLOCK_LEN-1)+BLOCK_LEN+(ELEMENTS/BLOCK_LEN-2)
//   reads (45 at 256/16); after the walk, ST_DONE registers the result and returns to idle
// one item at a time; the element and block-sum read ports set the pace; ST_DONE waits on out_stall
// reset: synchronous; a clearing pass then zeroes both memories, input stalled
module block_range_sum_table #(
  parameter int ELEMENTS  = brst_pkg::ELEMENTS_DEF,
  parameter int BLOCK_LEN = brst_pkg::BLOCK_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [brst_pkg::POS_W-1:0]        position,
  input  logic [brst_pkg::POS_W-1:0]        range_end,
  input  logic signed [brst_pkg::VAL_W-1:0] new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [brst_pkg::SUM_W-1:0] range_sum
);

  localparam int NUM_BLOCKS = (ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int IW  = $clog2(ELEMENTS);
  localparam int BAW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic                       e_we;
  logic [IW-1:0]              e_waddr;
  logic [brst_pkg::VAL_W-1:0] e_wdata;
  logic [IW-1:0]              e_raddr;
  logic [brst_pkg::VAL_W-1:0] e_rdata;
  logic                       b_we;
  logic [BAW-1:0]             b_waddr;
  logic [brst_pkg::SUM_W-1:0] b_wdata;
  logic [BAW-1:0]             b_raddr;
  logic [brst_pkg::SUM_W-1:0] b_rdata;

  brst_ram #(
    .WIDTH (brst_pkg::VAL_W),
    .DEPTH (ELEMENTS)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  brst_ram #(
    .WIDTH (brst_pkg::SUM_W),
    .DEPTH (NUM_BLOCKS)
  ) u_bsum_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  brst_seq #(
    .ELEMENTS  (ELEMENTS),
    .BLOCK_LEN (BLOCK_LEN)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .position  (position),
    .range_end (range_end),
    .new_value (new_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .range_sum (range_sum),
    .e_we      (e_we),
    .e_waddr   (e_waddr),
    .e_wdata   (e_wdata),
    .e_raddr   (e_raddr),
    .e_rdata   (e_rdata),
    .b_we      (b_we),
    .b_waddr   (b_waddr),
    .b_wdata   (b_wdata),
    .b_raddr   (b_raddr),
    .b_rdata   (b_rdata)
  );

endmodule

>>> design/brst_ram.sv
module brst_ram #(
  parameter int WIDTH = brst_pkg::SUM_W,
  parameter int DEPTH = brst_pkg::ELEMENTS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/brst_seq.sv
module brst_seq #(
  parameter int ELEMENTS  = brst_pkg::ELEMENTS_DEF,
  parameter int BLOCK_LEN = brst_pkg::BLOCK_LEN_DEF,
  localparam int NUM_BLOCKS = (ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN,
  localparam int IW  = $clog2(ELEMENTS),
  localparam int BAW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [brst_pkg::POS_W-1:0]        position,
  input  logic [brst_pkg::POS_W-1:0]        range_end,
  input  logic signed [brst_pkg::VAL_W-1:0] new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [brst_pkg::SUM_W-1:0] range_sum,
  output logic                              e_we,
  output logic [IW-1:0]                     e_waddr,
  output logic [brst_pkg::VAL_W-1:0]        e_wdata,
  output logic [IW-1:0]                     e_raddr,
  input  logic [brst_pkg::VAL_W-1:0]        e_rdata,
  output logic                              b_we,
  output logic [BAW-1:0]                    b_waddr,
  output logic [brst_pkg::SUM_W-1:0]        b_wdata,
  output logic [BAW-1:0]                    b_raddr,
  input  logic [brst_pkg::SUM_W-1:0]        b_rdata
);

  `include "block_range_sum_table_defines.svh"

  localparam int CW = ((IW > brst_pkg::POS_W) ? IW : brst_pkg::POS_W) + 2;
  localparam int BW = $clog2(BLOCK_LEN);

  brst_pkg::state_t state, state_next;
  logic [CW-1:0]                 i, i_next;
  logic [CW-1:0]                 rend, rend_next;
  logic [brst_pkg::SUM_W-1:0]    acc, acc_next;
  logic [brst_pkg::VAL_W-1:0]    wr_val, wr_val_next;
  logic                          pend_e, pend_e_next;
  logic                          pend_b, pend_b_next;
  logic                          load_out;

  logic                          accept;
  logic [CW-1:0]                 pos_w;
  logic [CW-1:0]                 rsat;
  logic [CW-1:0]                 cur;
  logic [CW-1:0]                 cur_blk;
  logic [CW-1:0]                 i_blk;

  assign accept  = in_valid && !in_stall;
  assign pos_w   = CW'(position);
  assign rsat    = (CW'(range_end) >= CW'(ELEMENTS)) ? CW'(ELEMENTS - 1) : CW'(range_end);
  // read address comes straight from the item while idle
  assign cur     = (state == brst_pkg::ST_IDLE) ? pos_w : i;
  assign cur_blk = cur >> BW;
  assign i_blk   = i >> BW;

  assign e_raddr = cur[IW-1:0];
  assign b_raddr = cur_blk[BAW-1:0];
  assign e_waddr = i[IW-1:0];
  assign b_waddr = (state == brst_pkg::ST_CLEAR) ? i[BAW-1:0] : i_blk[BAW-1:0];

  always_comb begin
    state_next  = state;
    i_next      = i;
    rend_next   = rend;
    wr_val_next = wr_val;
    pend_e_next = 1'b0;
    pend_b_next = 1'b0;
    load_out    = 1'b0;
    in_stall    = 1'b1;
    e_we        = 1'b0;
    e_wdata     = '0;
    b_we        = 1'b0;
    b_wdata     = '0;

    acc_next = acc;
    if (pend_e) begin
      acc_next = acc + brst_pkg::sext_val(e_rdata);
    end else if (pend_b) begin
      acc_next = acc + b_rdata;
    end

    unique case (state)
      brst_pkg::ST_CLEAR: begin
        e_we   = 1'b1;
        b_we   = (i < CW'(NUM_BLOCKS));
        i_next = i + CW'(1);
        if (i == CW'(ELEMENTS - 1)) begin
          state_next = brst_pkg::ST_IDLE;
        end
      end
      brst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          i_next      = pos_w;
          wr_val_next = new_value;
          if (func == brst_pkg::FUNC_QUERY) begin
            rend_next = rsat;
            acc_next  = '0;
            state_next = (pos_w > rsat) ? brst_pkg::ST_DONE : brst_pkg::ST_WALK;
          end else if (pos_w < CW'(ELEMENTS)) begin
            state_next = brst_pkg::ST_WRITE;
          end
        end
      end
      brst_pkg::ST_WRITE: begin
        // old element and block sum were read in the accept cycle
        e_we       = 1'b1;
        e_wdata    = wr_val;
        b_we       = 1'b1;
        b_wdata    = b_rdata + brst_pkg::sext_val(wr_val) - brst_pkg::sext_val(e_rdata);
        state_next = brst_pkg::ST_IDLE;
      end
      brst_pkg::ST_WALK: begin
        if (i > rend) begin
          state_next = brst_pkg::ST_DONE;
        end else if (i[BW-1:0] != '0 || (i + CW'(BLOCK_LEN)) > rend) begin
          pend_e_next = 1'b1;
          i_next      = i + CW'(1);
        end else begin
          pend_b_next = 1'b1;
          i_next      = i + CW'(BLOCK_LEN);
        end
      end
      brst_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = brst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= brst_pkg::ST_CLEAR;
      i      <= '0;
      pend_e <= 1'b0;
      pend_b <= 1'b0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      pend_e <= pend_e_next;
      pend_b <= pend_b_next;
    end
  end

  always_ff @(posedge clk) begin
    rend   <= rend_next;
    acc    <= acc_next;
    wr_val <= wr_val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      range_sum <= acc;
    end
  end

  `BRST_ASSERT(a_write_commits, (accept && func == brst_pkg::FUNC_WRITE && pos_w < CW'(ELEMENTS)) |=> (e_we && b_we), "write item not committed")
  `BRST_ASSERT(a_empty_zero, (accept && func == brst_pkg::FUNC_QUERY && pos_w > rsat) |=> (state == brst_pkg::ST_DONE && acc == '0), "empty range not zero")
  `BRST_ASSERT(a_walk_bound, (state == brst_pkg::ST_WALK) |-> (i <= rend + CW'(1)), "walk index overran range")
  `BRST_ASSERT(a_one_pending, !(pend_e && pend_b), "two reads pending")
  `BRST_ASSERT(a_no_overwrite, (out_valid && out_stall) |=> (out_valid && $stable(range_sum)), "result overwritten while stalled")

endmodule
